// ----- rtl/integer_to_ascii_formatter_top_macros.svh -----
// Assertion macros shared by the formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ITAF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ITAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/itaf_pkg.sv -----
// Shared constants, types and a function of the integer to ASCII formatter.
package itaf_pkg;

    localparam int DIGIT_DEPTH = 16;
    localparam int VALUE_WIDTH = 64;

    localparam int IDX_W      = $clog2(DIGIT_DEPTH);
    localparam int PTR_DIGITS = ((VALUE_WIDTH + 3) / 4 > DIGIT_DEPTH) ?
                                DIGIT_DEPTH : (VALUE_WIDTH + 3) / 4;

    localparam logic [64:0] VALUE_MASK_WIDE = (65'(1) << VALUE_WIDTH) - 65'(1);
    localparam logic [63:0] VALUE_MASK      = VALUE_MASK_WIDE[63:0];

    // floor(x * DEC_RECIP / 2^35) equals floor(x / 10) for every 32-bit x.
    localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
    localparam int          DEC_SHIFT = 35;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] HEX_OFS  = 8'h37;

    typedef enum logic [1:0] {
        ACT_SDEC = 2'd0,
        ACT_UDEC = 2'd1,
        ACT_HEX  = 2'd2,
        ACT_PTR  = 2'd3
    } itaf_action_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic fix;
        logic hex;
    } itaf_div_ctrl_t;

    typedef struct packed {
        logic [3:0] rem;
        logic       quot_zero;
    } itaf_div_stat_t;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        return 8'(d) + ((d > 4'd9) ? HEX_OFS : CH_ZERO);
    endfunction

endpackage

// ----- rtl/itaf_divu.sv -----
// Shared digit unit: divides the working value by ten or sixteen per step.
module itaf_divu import itaf_pkg::*; (
    input  logic           aclk,
    input  itaf_div_ctrl_t ctrl,
    input  logic [63:0]    operand,
    output itaf_div_stat_t stat
);

    logic [63:0] work_reg;
    logic [63:0] prod_reg;
    logic [63:0] quot;
    logic [28:0] dec_q;
    logic [31:0] dec_q10;
    logic [3:0]  rem;

    always_comb begin
        dec_q   = prod_reg[63:DEC_SHIFT];
        dec_q10 = {dec_q, 3'b000} + {2'b00, dec_q, 1'b0};
        if (ctrl.hex) begin
            quot = work_reg >> 4;
            rem  = work_reg[3:0];
        end else begin
            quot = 64'(dec_q);
            rem  = work_reg[3:0] - dec_q10[3:0];
        end
        stat.rem       = rem;
        stat.quot_zero = (quot == 64'd0);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            work_reg <= operand;
        end else if (ctrl.fix) begin
            work_reg <= quot;
        end
        if (ctrl.mul) begin
            prod_reg <= work_reg[31:0] * DEC_RECIP;
        end
    end

endmodule

// ----- rtl/itaf_dstore.sv -----
// Digit store: one four-bit digit per entry, read out as an ASCII character.
module itaf_dstore import itaf_pkg::*; (
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [3:0]       wdata,
    input  logic [IDX_W-1:0] raddr,
    output logic [7:0]       rchar
);

    logic [3:0] digit_reg [DIGIT_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            digit_reg[waddr] <= wdata;
        end
    end

    assign rchar = hex_char(digit_reg[raddr]);

endmodule

// ----- rtl/integer_to_ascii_formatter_top.sv -----
// Top level of the integer to ASCII formatter: sequencer and output register.
//
//  Channel | Dir | Word contents                          | Accepted when
//  --------+-----+----------------------------------------+---------------------------
//  s_      | in  | tdata[1:0] action, tdata[65:2] value   | s_tvalid && s_tready
//  m_      | out | tdata[7:0] character, tlast last       | m_tvalid && m_tready
//
// One number at a time: the word is taken in, then each digit takes two steps
// of the shared digit unit (multiply by the reciprocal of ten, then correct and
// store; hex digits take the same two steps), and then the characters go out,
// 18 of them for a pointer (two prefix characters and 16 digits).
// A character waiting in the output register only holds the character loop, and
// s_tready is high only while the sequencer waits; aresetn is synchronous, low.
`include "integer_to_ascii_formatter_top_macros.svh"

module integer_to_ascii_formatter_top import itaf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [1:0] action, [65:2] value, rest zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] character
    output logic                 m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic             ptr_reg, ptr_next;
    logic             hex_reg, hex_next;
    logic             neg_reg, neg_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]       pre_reg, pre_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [7:0]       m_char_reg, m_char_next;
    logic             m_last_reg, m_last_next;

    itaf_action_t   action;
    logic [63:0]    value;
    logic [63:0]    operand;
    itaf_div_ctrl_t div_ctrl;
    itaf_div_stat_t div_stat;
    logic           digit_we;
    logic [7:0]     digit_char;
    logic           more_digits;
    logic           slot_free;
    logic [7:0]     prefix_char;

    assign action = itaf_action_t'(s_tdata[1:0]);
    assign value  = s_tdata[65:2];

    itaf_divu u_divu (
        .aclk    (aclk),
        .ctrl    (div_ctrl),
        .operand (operand),
        .stat    (div_stat)
    );

    itaf_dstore u_dstore (
        .aclk  (aclk),
        .we    (digit_we),
        .waddr (idx_reg),
        .wdata (div_stat.rem),
        .raddr (idx_reg),
        .rchar (digit_char)
    );

    // Pointer text leads with "0x", a negative signed number with a minus.
    assign prefix_char = ptr_reg ? ((pre_reg == 2'd2) ? CH_ZERO : CH_X) : CH_MINUS;

    // Pointers always give a fixed number of digits; the other modes stop
    // as soon as the quotient reaches zero.
    assign more_digits = ptr_reg ? (idx_reg != IDX_W'(PTR_DIGITS - 1))
                                 : (!div_stat.quot_zero &&
                                    idx_reg != IDX_W'(DIGIT_DEPTH - 1));

    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        hex_next      = hex_reg;
        neg_next      = neg_reg;
        idx_next      = idx_reg;
        pre_next      = pre_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;
        operand       = 64'(value[31:0]);
        div_ctrl      = '0;
        div_ctrl.hex  = hex_reg || ptr_reg;
        digit_we      = 1'b0;

        case (action)
            ACT_SDEC: operand = value[31] ? 64'((~value[31:0]) + 32'd1)
                                          : 64'(value[31:0]);
            ACT_PTR:  operand = value & VALUE_MASK;
            default:  operand = 64'(value[31:0]);
        endcase

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    div_ctrl.load = 1'b1;
                    ptr_next      = (action == ACT_PTR);
                    hex_next      = (action == ACT_HEX);
                    neg_next      = (action == ACT_SDEC) && value[31];
                    idx_next      = '0;
                    if (action == ACT_PTR) begin
                        pre_next = 2'd2;
                    end else if (action == ACT_SDEC && value[31]) begin
                        pre_next = 2'd1;
                    end else begin
                        pre_next = 2'd0;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                div_ctrl.mul = 1'b1;
                state_next   = ST_FIX;
            end
            ST_FIX: begin
                div_ctrl.fix = 1'b1;
                digit_we     = 1'b1;
                if (more_digits) begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Characters go out most significant first; the store is
                // read downward from the top digit.
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    if (pre_reg != 2'd0) begin
                        m_char_next = prefix_char;
                        m_last_next = 1'b0;
                        pre_next    = pre_reg - 2'd1;
                    end else begin
                        m_char_next = digit_char;
                        m_last_next = (idx_reg == '0);
                        if (idx_reg == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            idx_next = idx_reg - IDX_W'(1);
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            ptr_reg      <= 1'b0;
            hex_reg      <= 1'b0;
            neg_reg      <= 1'b0;
            idx_reg      <= '0;
            pre_reg      <= 2'd0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            ptr_reg      <= ptr_next;
            hex_reg      <= hex_next;
            neg_reg      <= neg_next;
            idx_reg      <= idx_next;
            pre_reg      <= pre_next;
        end
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tlast  = m_last_reg;

    // A decimal step must leave a remainder below ten.
    `ITAF_ASSERT_NOW(a_dec_rem_range, state_reg == ST_FIX && !hex_reg && !ptr_reg, div_stat.rem <= 4'd9, "decimal remainder out of range")
    // A prefix is only pending for pointers or negative numbers.
    `ITAF_ASSERT_NOW(a_prefix_cause, state_reg == ST_EMIT && pre_reg != 2'd0, ptr_reg || neg_reg, "prefix pending without cause")
    // An accepted number always starts a divide step with an empty store index.
    `ITAF_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg == ST_MUL && idx_reg == '0, "accepted number did not start digit generation")

endmodule
